// ----- sv/sorted_key_value_table_assert.svh -----
// --------------------------------------------------------------------------
// sorted_key_value_table_assert.svh
// assertion macros used by the checker file
// --------------------------------------------------------------------------
`ifndef SORTED_KEY_VALUE_TABLE_ASSERT_SVH
`define SORTED_KEY_VALUE_TABLE_ASSERT_SVH

// same-cycle implication, quiet during reset
`define SKVT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, quiet during reset
`define SKVT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/skvt_pkg.sv -----
// --------------------------------------------------------------------------
// skvt_pkg
// types and constants of the sorted key/value table
// --------------------------------------------------------------------------
`default_nettype none

package skvt_pkg;

    localparam int CAPACITY_DEF   = 64;
    localparam int KEY_BITS_DEF   = 32;
    localparam int VALUE_BITS_DEF = 32;

    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_DELETE = 2'd1,
        REQ_SEARCH = 2'd2,
        REQ_UPDATE = 2'd3
    } t_req_type;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_EXISTS    = 2'd1,
        STATUS_NOT_FOUND = 2'd2,
        STATUS_FULL      = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_DELETE = 2'd2,
        CELL_UPDATE = 2'd3
    } t_cell_op;

    typedef enum logic {
        STATE_IDLE  = 1'b0,
        STATE_APPLY = 1'b1
    } t_state;

    typedef struct packed {
        logic     capture;
        t_cell_op op;
    } t_cell_ctrl;

endpackage

`default_nettype wire

// ----- sv/skvt_cell.sv -----
// --------------------------------------------------------------------------
// skvt_cell
// one slot of the sorted table: compares against the request key and
// shifts its entry to or from a neighbor
// --------------------------------------------------------------------------
`default_nettype none

module skvt_cell #(
    parameter int KEY_BITS   = skvt_pkg::KEY_BITS_DEF,
    parameter int VALUE_BITS = skvt_pkg::VALUE_BITS_DEF
) (
    input  wire logic                         i_clk,
    input  wire skvt_pkg::t_cell_ctrl         i_ctrl,
    input  wire logic                         i_occupied,
    input  wire logic signed [KEY_BITS-1:0]   i_cmp_key,
    input  wire logic signed [KEY_BITS-1:0]   i_new_key,
    input  wire logic        [VALUE_BITS-1:0] i_new_value,
    input  wire logic                         i_left_lt,
    input  wire logic signed [KEY_BITS-1:0]   i_left_key,
    input  wire logic        [VALUE_BITS-1:0] i_left_value,
    input  wire logic signed [KEY_BITS-1:0]   i_right_key,
    input  wire logic        [VALUE_BITS-1:0] i_right_value,
    output logic signed      [KEY_BITS-1:0]   o_key,
    output logic             [VALUE_BITS-1:0] o_value,
    output logic                              o_lt,
    output logic                              o_eq
);
    import skvt_pkg::*;

    logic signed [KEY_BITS-1:0]   r_key;
    logic        [VALUE_BITS-1:0] r_value;
    logic                         r_lt;
    logic                         r_eq;
    logic signed [KEY_BITS-1:0]   n_key;
    logic        [VALUE_BITS-1:0] n_value;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.capture) begin
            r_lt <= i_occupied && (r_key < i_cmp_key);
            r_eq <= i_occupied && (r_key == i_cmp_key);
        end
    end

    always_comb begin
        n_key   = r_key;
        n_value = r_value;
        unique case (i_ctrl.op)
            CELL_HOLD: begin
            end
            CELL_INSERT: begin
                if (!r_lt) begin
                    if (i_left_lt) begin
                        n_key   = i_new_key;
                        n_value = i_new_value;
                    end else begin
                        n_key   = i_left_key;
                        n_value = i_left_value;
                    end
                end
            end
            CELL_DELETE: begin
                if (!r_lt) begin
                    n_key   = i_right_key;
                    n_value = i_right_value;
                end
            end
            CELL_UPDATE: begin
                if (r_eq) begin
                    n_value = i_new_value;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_key   <= n_key;
        r_value <= n_value;
    end

    assign o_key   = r_key;
    assign o_value = r_value;
    assign o_lt    = r_lt;
    assign o_eq    = r_eq;

endmodule

`default_nettype wire

// ----- sv/sorted_key_value_table.sv -----
// --------------------------------------------------------------------------
// sorted_key_value_table: sorted key/value store in a chain of compare/shift cells
// the cells compare at the request transfer edge, then shift in the APPLY state, which
// registers the response; APPLY waits while a response waits for ready, and no new request is taken until it ends
// synchronous active-low reset empties the table and drops any pending response
// --------------------------------------------------------------------------
`default_nettype none

module sorted_key_value_table #(
    parameter int  CAPACITY   = skvt_pkg::CAPACITY_DEF,
    parameter int  KEY_BITS   = skvt_pkg::KEY_BITS_DEF,
    parameter int  VALUE_BITS = skvt_pkg::VALUE_BITS_DEF,
    localparam int COUNT_BITS = $clog2(CAPACITY + 1)
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_req_valid,
    output logic                              o_req_ready,
    input  wire logic        [1:0]            i_req_type,
    input  wire logic signed [KEY_BITS-1:0]   i_key,
    input  wire logic        [VALUE_BITS-1:0] i_value_in,
    output logic                              o_rsp_valid,
    input  wire logic                         i_rsp_ready,
    output logic             [1:0]            o_status,
    output logic             [VALUE_BITS-1:0] o_value_out,
    output logic             [COUNT_BITS-1:0] o_entry_count
);
    import skvt_pkg::*;

    t_state                       r_state;
    t_state                       n_state;
    logic        [1:0]            r_req_type;
    logic signed [KEY_BITS-1:0]   r_req_key;
    logic        [VALUE_BITS-1:0] r_req_value;
    logic        [COUNT_BITS-1:0] r_count;
    logic        [COUNT_BITS-1:0] n_count;
    logic                         r_rsp_valid;
    logic                         n_rsp_valid;
    logic        [1:0]            r_status;
    logic        [VALUE_BITS-1:0] r_value_out;

    logic                         req_xfer;
    logic                         apply_go;
    logic                         hit;
    logic                         full;
    logic        [VALUE_BITS-1:0] hit_value;
    t_status                      status;
    logic        [VALUE_BITS-1:0] value_out;
    t_cell_op                     op;
    t_cell_ctrl                   ctrl;

    logic signed [KEY_BITS-1:0]   cell_key   [CAPACITY];
    logic        [VALUE_BITS-1:0] cell_value [CAPACITY];
    logic        [CAPACITY-1:0]   cell_lt;
    logic        [CAPACITY-1:0]   cell_eq;
    logic        [CAPACITY-1:0]   cell_occ;

    // state machine
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            STATE_IDLE:  if (req_xfer) n_state = STATE_APPLY;
            STATE_APPLY: if (apply_go) n_state = STATE_IDLE;
            default:     n_state = STATE_IDLE;
        endcase
    end

    always_comb begin
        o_req_ready = (r_state == STATE_IDLE);
        apply_go    = (r_state == STATE_APPLY) && (!r_rsp_valid || i_rsp_ready);
    end

    assign req_xfer = i_req_valid && o_req_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= STATE_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (req_xfer) begin
            r_req_type  <= i_req_type;
            r_req_key   <= i_key;
            r_req_value <= i_value_in;
        end
    end

    // hit detection and value read over the registered cell flags
    always_comb begin
        hit_value = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            hit_value = hit_value | (cell_value[i] & {VALUE_BITS{cell_eq[i]}});
        end
    end

    assign hit  = |cell_eq;
    assign full = (r_count == COUNT_BITS'(CAPACITY));

    always_comb begin
        status    = STATUS_OK;
        value_out = '0;
        op        = CELL_HOLD;
        n_count   = r_count;
        unique case (t_req_type'(r_req_type))
            REQ_INSERT: begin
                if (hit) begin
                    status = STATUS_EXISTS;
                end else if (full) begin
                    status = STATUS_FULL;
                end else begin
                    op      = CELL_INSERT;
                    n_count = r_count + COUNT_BITS'(1);
                end
            end
            REQ_DELETE: begin
                if (hit) begin
                    op        = CELL_DELETE;
                    value_out = hit_value;
                    n_count   = r_count - COUNT_BITS'(1);
                end else begin
                    status = STATUS_NOT_FOUND;
                end
            end
            REQ_SEARCH: begin
                if (hit) begin
                    value_out = hit_value;
                end else begin
                    status = STATUS_NOT_FOUND;
                end
            end
            REQ_UPDATE: begin
                if (hit) begin
                    op = CELL_UPDATE;
                end else begin
                    status = STATUS_NOT_FOUND;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        ctrl.capture = req_xfer;
        ctrl.op      = apply_go ? op : CELL_HOLD;
    end

    always_comb begin
        n_rsp_valid = r_rsp_valid;
        if (apply_go) begin
            n_rsp_valid = 1'b1;
        end else if (i_rsp_ready) begin
            n_rsp_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_valid <= 1'b0;
            r_count     <= '0;
        end else begin
            r_rsp_valid <= n_rsp_valid;
            if (apply_go) begin
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (apply_go) begin
            r_status    <= status;
            r_value_out <= value_out;
        end
    end

    assign o_rsp_valid   = r_rsp_valid;
    assign o_status      = r_status;
    assign o_value_out   = r_value_out;
    assign o_entry_count = r_count;

    // cell chain
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic                         left_lt;
        logic signed [KEY_BITS-1:0]   left_key;
        logic        [VALUE_BITS-1:0] left_value;
        logic signed [KEY_BITS-1:0]   right_key;
        logic        [VALUE_BITS-1:0] right_value;

        assign cell_occ[g] = (COUNT_BITS'(g) < r_count);

        if (g == 0) begin : g_head
            assign left_lt    = 1'b1;
            assign left_key   = r_req_key;
            assign left_value = r_req_value;
        end else begin : g_body
            assign left_lt    = cell_lt[g-1];
            assign left_key   = cell_key[g-1];
            assign left_value = cell_value[g-1];
        end

        if (g == CAPACITY - 1) begin : g_tail
            assign right_key   = cell_key[g];
            assign right_value = cell_value[g];
        end else begin : g_link
            assign right_key   = cell_key[g+1];
            assign right_value = cell_value[g+1];
        end

        skvt_cell #(
            .KEY_BITS   (KEY_BITS),
            .VALUE_BITS (VALUE_BITS)
        ) u_cell (
            .i_clk         (i_clk),
            .i_ctrl        (ctrl),
            .i_occupied    (cell_occ[g]),
            .i_cmp_key     (i_key),
            .i_new_key     (r_req_key),
            .i_new_value   (r_req_value),
            .i_left_lt     (left_lt),
            .i_left_key    (left_key),
            .i_left_value  (left_value),
            .i_right_key   (right_key),
            .i_right_value (right_value),
            .o_key         (cell_key[g]),
            .o_value       (cell_value[g]),
            .o_lt          (cell_lt[g]),
            .o_eq          (cell_eq[g])
        );
    end

endmodule

`default_nettype wire

// ----- sv/skvt_checker.sv -----
// --------------------------------------------------------------------------
// skvt_checker
// response-side checks on the ports of the sorted key/value table
// --------------------------------------------------------------------------
`default_nettype none

`include "sorted_key_value_table_assert.svh"

module skvt_checker #(
    parameter int  CAPACITY   = skvt_pkg::CAPACITY_DEF,
    parameter int  VALUE_BITS = skvt_pkg::VALUE_BITS_DEF,
    localparam int COUNT_BITS = $clog2(CAPACITY + 1)
) (
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  o_rsp_valid,
    input wire logic                  i_rsp_ready,
    input wire logic [1:0]            o_status,
    input wire logic [VALUE_BITS-1:0] o_value_out,
    input wire logic [COUNT_BITS-1:0] o_entry_count
);
    import skvt_pkg::*;

    `SKVT_ASSERT_NEXT(a_rsp_hold, o_rsp_valid && !i_rsp_ready,
        o_rsp_valid && $stable(o_entry_count), "response dropped while stalled")

    `SKVT_ASSERT_NOW(a_count_range, o_rsp_valid,
        o_entry_count <= COUNT_BITS'(CAPACITY), "entry count above capacity")

    `SKVT_ASSERT_NOW(a_fail_zero, o_rsp_valid && (o_status != STATUS_OK),
        o_value_out == '0, "failed request returned a value")

    `SKVT_ASSERT_NOW(a_full_count, o_rsp_valid && (o_status == STATUS_FULL),
        o_entry_count == COUNT_BITS'(CAPACITY), "full status with free room")

endmodule

bind sorted_key_value_table skvt_checker #(
    .CAPACITY   (CAPACITY),
    .VALUE_BITS (VALUE_BITS)
) u_skvt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_rsp_valid   (o_rsp_valid),
    .i_rsp_ready   (i_rsp_ready),
    .o_status      (o_status),
    .o_value_out   (o_value_out),
    .o_entry_count (o_entry_count)
);

`default_nettype wire

// ----- test/tb.sv -----
// --------------------------------------------------------------------------
// tb: self-checking bench for sorted_key_value_table
// A directed opening (empty-table misses, extreme keys, duplicate insert,
// search, update and delete hits and misses) is followed by random rounds.
// Each round fills the table past capacity, mixes all requests, then drains.
// Every accepted request runs through a shadow sorted table. The resulting
// status, value and entry count are queued and compared with each response.
// Both handshakes idle and stall at random.
// --------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import skvt_pkg::*;

    localparam int CAP            = CAPACITY_DEF;
    localparam int KEY_W          = KEY_BITS_DEF;
    localparam int VAL_W          = VALUE_BITS_DEF;
    localparam int COUNT_W        = $clog2(CAP + 1);
    localparam int KEY_SET_LEN    = 80;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = 16;

    typedef struct {
        t_req_type               op;
        logic signed [KEY_W-1:0] key;
        logic [VAL_W-1:0]        val;
        bit                      drain;
    } t_table_req;

    typedef struct {
        t_status            status;
        logic [VAL_W-1:0]   value;
        logic [COUNT_W-1:0] count;
    } t_table_rsp;

    logic                    i_clk       = 1'b0;
    logic                    i_rst_n     = 1'b0;
    logic                    i_req_valid = 1'b0;
    logic [1:0]              i_req_type  = REQ_SEARCH;
    logic signed [KEY_W-1:0] i_key       = '0;
    logic [VAL_W-1:0]        i_value_in  = '0;
    logic                    i_rsp_ready = 1'b0;
    logic                    o_req_ready;
    logic                    o_rsp_valid;
    logic [1:0]              o_status;
    logic [VAL_W-1:0]        o_value_out;
    logic [COUNT_W-1:0]      o_entry_count;

    t_table_req req_backlog[$];
    t_table_rsp awaited_rsps[$];

    logic signed [KEY_W-1:0] shadow_keys[CAP];
    logic [VAL_W-1:0]        shadow_vals[CAP];
    int                      shadow_count = 0;

    int failures      = 0;
    int reqs_sent     = 0;
    int status_tally[4] = '{0, 0, 0, 0};
    int peak_count    = 0;
    int send_hold     = 0;
    int recv_hold     = 0;
    bit send_calm     = 1'b0;
    bit recv_calm     = 1'b0;
    int quiet_cycles  = 0;

    sorted_key_value_table dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req_valid   (i_req_valid),
        .o_req_ready   (o_req_ready),
        .i_req_type    (i_req_type),
        .i_key         (i_key),
        .i_value_in    (i_value_in),
        .o_rsp_valid   (o_rsp_valid),
        .i_rsp_ready   (i_rsp_ready),
        .o_status      (o_status),
        .o_value_out   (o_value_out),
        .o_entry_count (o_entry_count)
    );

    always #6ns i_clk = ~i_clk;

    function automatic t_table_rsp table_outcome(t_table_req r);
        t_table_rsp res;
        int         pos;
        bit         hit;
        res.status = STATUS_OK;
        res.value  = '0;
        pos = 0;
        while (pos < shadow_count && shadow_keys[pos] < r.key) pos++;
        hit = (pos < shadow_count) && (shadow_keys[pos] == r.key);
        case (r.op)
            REQ_INSERT: begin
                if (hit) begin
                    res.status = STATUS_EXISTS;
                end else if (shadow_count >= CAP) begin
                    res.status = STATUS_FULL;
                end else begin
                    for (int i = shadow_count; i > pos; i--) begin
                        shadow_keys[i] = shadow_keys[i-1];
                        shadow_vals[i] = shadow_vals[i-1];
                    end
                    shadow_keys[pos] = r.key;
                    shadow_vals[pos] = r.val;
                    shadow_count++;
                end
            end
            REQ_DELETE: begin
                if (!hit) begin
                    res.status = STATUS_NOT_FOUND;
                end else begin
                    res.value = shadow_vals[pos];
                    for (int i = pos; i < shadow_count - 1; i++) begin
                        shadow_keys[i] = shadow_keys[i+1];
                        shadow_vals[i] = shadow_vals[i+1];
                    end
                    shadow_count--;
                end
            end
            REQ_SEARCH: begin
                if (!hit) res.status = STATUS_NOT_FOUND;
                else res.value = shadow_vals[pos];
            end
            REQ_UPDATE: begin
                if (!hit) res.status = STATUS_NOT_FOUND;
                else shadow_vals[pos] = r.val;
            end
        endcase
        res.count = COUNT_W'(shadow_count);
        return res;
    endfunction

    task automatic queue_request(t_req_type op, logic signed [KEY_W-1:0] key,
                                 logic [VAL_W-1:0] val, bit drain);
        t_table_req r;
        r.op    = op;
        r.key   = key;
        r.val   = val;
        r.drain = drain;
        req_backlog.push_back(r);
    endtask

    // request driver
    always @(posedge i_clk) begin : drive_requests
        bit fire;
        fire = i_req_valid && o_req_ready;
        if (!i_rst_n) begin
            i_req_valid <= 1'b0;
            send_hold = 0;
        end else begin
            if (fire) begin
                awaited_rsps.push_back(table_outcome(req_backlog[0]));
                void'(req_backlog.pop_front());
                reqs_sent++;
                if ($urandom_range(0, 39) == 0) send_calm = !send_calm;
                send_hold = send_calm ? 0 : $urandom_range(0, 13);
            end
            if (fire || !i_req_valid) begin
                if (send_hold == 0 && req_backlog.size() != 0 &&
                    (!req_backlog[0].drain || awaited_rsps.size() == 0)) begin
                    i_req_valid <= 1'b1;
                    i_req_type  <= req_backlog[0].op;
                    i_key       <= req_backlog[0].key;
                    i_value_in  <= req_backlog[0].val;
                end else begin
                    i_req_valid <= 1'b0;
                    if (send_hold != 0) send_hold--;
                end
            end
        end
    end

    // response monitor
    always @(posedge i_clk) begin : check_responses
        t_table_rsp want;
        if (!i_rst_n) begin
            i_rsp_ready <= 1'b0;
            recv_hold = 0;
        end else if (o_rsp_valid && i_rsp_ready) begin
            if (awaited_rsps.size() == 0) begin
                $error("response transfer with no request outstanding");
                failures++;
            end else begin
                want = awaited_rsps.pop_front();
                if (o_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_status);
                    failures++;
                end
                if (o_value_out !== want.value) begin
                    $error("value_out: expected %08h, got %08h", want.value, o_value_out);
                    failures++;
                end
                if (o_entry_count !== want.count) begin
                    $error("entry_count: expected %0d, got %0d", want.count, o_entry_count);
                    failures++;
                end
                status_tally[want.status]++;
                if (want.count > peak_count) peak_count = want.count;
            end
            if ($urandom_range(0, 39) == 0) recv_calm = !recv_calm;
            recv_hold = recv_calm ? 0 : $urandom_range(0, 13);
            i_rsp_ready <= (recv_hold == 0);
        end else if (!i_rsp_ready) begin
            if (recv_hold != 0) recv_hold--;
            i_rsp_ready <= (recv_hold == 0);
        end
    end

    // watchdog on transfer activity
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_req_valid && o_req_ready) || (o_rsp_valid && i_rsp_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        logic signed [KEY_W-1:0] pool[KEY_SET_LEN];
        logic signed [KEY_W-1:0] key;
        t_req_type               op;
        int                      ins_pct;
        int                      del_pct;
        int                      roll;

        pool[0] = {1'b1, {(KEY_W-1){1'b0}}};
        pool[1] = {1'b0, {(KEY_W-1){1'b1}}};
        pool[2] = '0;
        pool[3] = '1;
        for (int i = 4; i < KEY_SET_LEN; i++) pool[i] = $urandom;

        // empty table misses, extreme keys, duplicates, hits and misses
        queue_request(REQ_SEARCH, pool[0], $urandom, 1'b0);
        queue_request(REQ_DELETE, pool[1], $urandom, 1'b0);
        queue_request(REQ_UPDATE, pool[2], $urandom, 1'b0);
        queue_request(REQ_INSERT, pool[1], '1, 1'b0);
        queue_request(REQ_INSERT, pool[0], '0, 1'b0);
        queue_request(REQ_INSERT, pool[2], 32'h5555_5555, 1'b0);
        queue_request(REQ_INSERT, pool[3], 32'haaaa_aaaa, 1'b0);
        queue_request(REQ_INSERT, 32'sd1, 32'h0000_0001, 1'b0);
        queue_request(REQ_INSERT, pool[1], 32'h1234_5678, 1'b0);
        queue_request(REQ_INSERT, pool[0], 32'h8765_4321, 1'b0);
        queue_request(REQ_SEARCH, pool[0], $urandom, 1'b0);
        queue_request(REQ_SEARCH, pool[1], $urandom, 1'b0);
        queue_request(REQ_SEARCH, 32'sd2, $urandom, 1'b0);
        queue_request(REQ_UPDATE, pool[2], 32'hdead_beef, 1'b0);
        queue_request(REQ_UPDATE, -32'sd2, 32'hffff_0000, 1'b0);
        queue_request(REQ_SEARCH, pool[2], $urandom, 1'b0);
        queue_request(REQ_DELETE, pool[3], $urandom, 1'b0);
        queue_request(REQ_DELETE, pool[3], $urandom, 1'b0);
        queue_request(REQ_SEARCH, pool[3], $urandom, 1'b0);
        queue_request(REQ_DELETE, pool[0], $urandom, 1'b0);
        queue_request(REQ_DELETE, pool[1], $urandom, 1'b0);
        queue_request(REQ_INSERT, pool[1], '0, 1'b0);
        queue_request(REQ_SEARCH, pool[1], $urandom, 1'b0);

        // rounds of fill past capacity, mixed traffic, then drain
        for (int r = 0; r < 3; r++) begin
            for (int n = 0; n < 310; n++) begin
                if (n < 130) begin
                    ins_pct = 75;
                    del_pct = 5;
                end else if (n < 210) begin
                    ins_pct = 30;
                    del_pct = 25;
                end else begin
                    ins_pct = 10;
                    del_pct = 70;
                end
                roll = $urandom_range(0, 99);
                if (roll < ins_pct) op = REQ_INSERT;
                else if (roll < ins_pct + del_pct) op = REQ_DELETE;
                else if (roll[0]) op = REQ_SEARCH;
                else op = REQ_UPDATE;
                if ($urandom_range(0, 9) == 0) key = $urandom;
                else key = pool[$urandom_range(0, KEY_SET_LEN - 1)];
                queue_request(op, key, $urandom, n == 0);
            end
        end

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (req_backlog.size() != 0 || awaited_rsps.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("%0d requests; results ok %0d, exists %0d, not found %0d, full %0d",
                 reqs_sent, status_tally[STATUS_OK], status_tally[STATUS_EXISTS],
                 status_tally[STATUS_NOT_FOUND], status_tally[STATUS_FULL]);
        $display("peak occupancy %0d of %0d entries", peak_count, CAP);
        if (failures == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+sv
sv/skvt_pkg.sv
sv/skvt_cell.sv
sv/sorted_key_value_table.sv
sv/skvt_checker.sv
test/tb.sv
